@@ rtl/core/itra_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itra_pkg
// Shared types and constants for the integer to radix ASCII converter.
// ----------------------------------------------------------------------------
package itra_pkg;

    // Radix limits
    localparam logic [5:0] BASE_MIN = 6'd2;
    localparam logic [5:0] BASE_MAX = 6'd36;

    // Character codes
    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_LETTER = 8'h37;  // 'A' minus ten
    localparam logic [5:0] DIGIT_TEN   = 6'd10;

    // Status from the serial divider to the sequencer
    typedef struct packed {
        logic       done;     // one-cycle pulse, quotient and remainder valid
        logic       quot_nz;  // quotient is nonzero
        logic [5:0] rem;      // remainder, below the radix
    } t_div_status;

    // Digit value to its ASCII character, digits ten and up are upper-case letters
    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [7:0] d8;
        d8 = {2'b00, d};
        if (d < DIGIT_TEN) begin
            digit_char = CHAR_ZERO + d8;
        end else begin
            digit_char = CHAR_LETTER + d8;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/itra_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itra_div
// Bit-serial restoring divider: one quotient bit per cycle, narrow remainder.
// ----------------------------------------------------------------------------
module itra_div #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [VALUE_WIDTH-1:0]   i_dividend,
    input  wire logic [5:0]               i_base,
    output itra_pkg::t_div_status         o_status,
    output logic      [VALUE_WIDTH-1:0]   o_quot
);

    localparam int SW = $clog2(VALUE_WIDTH);

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [SW-1:0]          r_step, n_step;
    logic [VALUE_WIDTH-1:0] r_quot, n_quot;
    logic [5:0]             r_rem, n_rem;
    logic                   r_nz, n_nz;

    logic [6:0] w_trial;
    logic [6:0] w_diff;
    logic       w_ge;

    // One shift-subtract step: bring in the next dividend bit
    assign w_trial = {r_rem, r_quot[VALUE_WIDTH-1]};
    assign w_ge    = w_trial >= {1'b0, i_base};
    assign w_diff  = w_trial - {1'b0, i_base};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_nz   = r_nz;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_quot = i_dividend;
            n_rem  = '0;
            n_nz   = 1'b0;
        end else if (r_busy) begin
            n_quot = {r_quot[VALUE_WIDTH-2:0], w_ge};
            n_rem  = w_ge ? w_diff[5:0] : w_trial[5:0];
            n_nz   = r_nz | w_ge;
            n_step = r_step + SW'(1);
            if (r_step == SW'(VALUE_WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_nz   <= n_nz;
    end

    assign o_status.done    = r_done;
    assign o_status.quot_nz = r_nz;
    assign o_status.rem     = r_rem;
    assign o_quot           = r_quot;

endmodule
`default_nettype wire

@@ rtl/core/int_to_radix_ascii_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// int_to_radix_ascii_unit
// Converts a signed integer to ASCII text in radix 2..36, one character per
// output transaction, most significant first, closed by a zero terminator.
//
//   Channel | Direction | Handshake           | Payload
//   input   | in        | i_valid / o_stall   | i_value, i_base
//   output  | out       | o_valid / i_stall   | o_out_char, o_last
//
// One item at a time. Each digit takes one pass through the bit-serial
// divider, and output stalls add to the time that an item takes.
// A radix outside 2..36 skips the divider and yields the terminator only.
// Reset (synchronous, active low) returns to idle and drops any output.
// o_stall is high from acceptance until the terminator is loaded.
// ----------------------------------------------------------------------------
module int_to_radix_ascii_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire logic [5:0]             i_base,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic      [7:0]             o_out_char,
    output logic                        o_last
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_SIGN  = 5'b00100,
        S_DIGIT = 5'b01000,
        S_TERM  = 5'b10000
    } t_state;

    t_state                 r_state, n_state;
    logic [5:0]             r_base, n_base;
    logic                   r_neg, n_neg;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [5:0]             r_stack [VALUE_WIDTH];
    logic [5:0]             n_stack [VALUE_WIDTH];
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_char, n_out_char;
    logic                   r_out_last, n_out_last;

    logic                   w_accept;
    logic                   w_base_ok;
    logic                   w_slot;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic                   w_start;
    logic [VALUE_WIDTH-1:0] w_dividend;
    itra_pkg::t_div_status  w_div;
    logic [VALUE_WIDTH-1:0] w_quot;

    assign o_stall   = (r_state != S_IDLE);
    assign w_accept  = i_valid && !o_stall;
    assign w_base_ok = (i_base >= itra_pkg::BASE_MIN) && (i_base <= itra_pkg::BASE_MAX);
    assign w_slot    = !r_out_valid || !i_stall;
    // Unsigned magnitude; the most negative value maps onto itself
    assign w_mag     = i_value[VALUE_WIDTH-1] ? (~i_value + VALUE_WIDTH'(1)) : i_value;

    // Serial divider
    itra_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dividend),
        .i_base     (r_state == S_IDLE ? i_base : r_base),
        .o_status   (w_div),
        .o_quot     (w_quot)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_stack     = r_stack;
        n_out_valid = r_out_valid && i_stall;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        w_start     = 1'b0;
        w_dividend  = w_quot;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_base = i_base;
                    n_neg  = i_value[VALUE_WIDTH-1];
                    n_cnt  = '0;
                    if (w_base_ok) begin
                        w_start    = 1'b1;
                        w_dividend = w_mag;
                        n_state    = S_DIV;
                    end else begin
                        n_state = S_TERM;
                    end
                end
            end
            S_DIV: begin
                // Push each remainder; digits come out least significant first
                if (w_div.done) begin
                    n_stack[0] = w_div.rem;
                    for (int i = 1; i < VALUE_WIDTH; i++) begin
                        n_stack[i] = r_stack[i-1];
                    end
                    n_cnt = r_cnt + CW'(1);
                    if (w_div.quot_nz) begin
                        w_start = 1'b1;
                    end else if (r_neg) begin
                        n_state = S_SIGN;
                    end else begin
                        n_state = S_DIGIT;
                    end
                end
            end
            S_SIGN: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = itra_pkg::CHAR_MINUS;
                    n_out_last  = 1'b0;
                    n_state     = S_DIGIT;
                end
            end
            S_DIGIT: begin
                // Pop most significant digit
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = itra_pkg::digit_char(r_stack[0]);
                    n_out_last  = 1'b0;
                    for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
                        n_stack[i] = r_stack[i+1];
                    end
                    n_cnt = r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        n_state = S_TERM;
                    end
                end
            end
            S_TERM: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    n_out_char  = itra_pkg::CHAR_NUL;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_base     <= n_base;
        r_neg      <= n_neg;
        r_cnt      <= n_cnt;
        r_stack    <= n_stack;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_valid    = r_out_valid;
    assign o_out_char = r_out_char;
    assign o_last     = r_out_last;

endmodule
`default_nettype wire
